FILE: rtl/xmse_pkg.sv
// ----------------------------------------------------------------------------
// xmse_pkg
// Types, codes and helpers shared by the ModRM/SIB encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xmse_pkg;

    // operand forms
    localparam logic [1:0] FUNC_RR = 2'd0;   // reg, reg
    localparam logic [1:0] FUNC_RI = 2'd1;   // reg, imm
    localparam logic [1:0] FUNC_RM = 2'd2;   // reg, [mem]
    localparam logic [1:0] FUNC_MR = 2'd3;   // [mem], reg

    // memory addressing forms
    localparam logic [2:0] MEM_BASE      = 3'd0;
    localparam logic [2:0] MEM_DISP32    = 3'd1;
    localparam logic [2:0] MEM_BASE_DISP = 3'd2;
    localparam logic [2:0] MEM_SIB_DISP  = 3'd3;
    localparam logic [2:0] MEM_IDX_DISP  = 3'd4;

    // ModRM mod field
    localparam logic [1:0] MOD_IND    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] REG_ESP    = 3'd4;   // rm code that selects SIB
    localparam logic [2:0] REG_EBP    = 3'd5;   // rm/base code for disp32
    localparam logic [7:0] SIB_ESP    = 8'h24;  // no index, base ESP

    localparam int unsigned MAX_BYTES = 7;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         opcode_byte;
        logic [2:0]         reg_sel;
        logic [2:0]         rm_sel;
        logic [2:0]         mem_form;
        logic [2:0]         base_sel;
        logic [2:0]         index_sel;
        logic [1:0]         scale_shift;
        logic signed [31:0] disp_value;
        logic signed [31:0] imm_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic [2:0] byte_pos;
        logic       last_byte;
    } out_item_t;

    // encoded instruction: bytes little-end first, byte 0 in [7:0]
    typedef struct packed {
        logic [8*MAX_BYTES-1:0] bytes;
        logic [2:0]             len;
    } enc_t;

    function automatic logic [7:0] modrm(input logic [1:0] mod,
                                         input logic [2:0] reg_f,
                                         input logic [2:0] rm_f);
        return {mod, reg_f, rm_f};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/xmse_encode.sv
// ----------------------------------------------------------------------------
// xmse_encode
// Combinational encoder: one registered instruction to its byte string.
// ----------------------------------------------------------------------------
`default_nettype none

module xmse_encode
    import xmse_pkg::*;
(
    input  in_item_t item,
    output enc_t     enc
);

    logic [23:0] head;      // opcode, ModRM, SIB
    logic [1:0]  hcount;
    logic [31:0] tail;      // immediate or displacement
    logic [2:0]  tcount;
    logic [1:0]  mod;
    logic        d_zero;
    logic        d_fits8;
    logic        i_fits8;
    logic        i_fits16;
    logic [2:0]  dsize;
    logic [7:0]  sib;

    assign d_zero   = (item.disp_value == 32'sd0);
    assign d_fits8  = (&item.disp_value[31:7]) | ~(|item.disp_value[31:7]);
    assign i_fits8  = (&item.imm_value[31:7])  | ~(|item.imm_value[31:7]);
    assign i_fits16 = (&item.imm_value[31:15]) | ~(|item.imm_value[31:15]);
    assign sib      = {item.scale_shift, item.index_sel, item.base_sel};

    // mod for [base+disp] forms; EBP base never uses mod 0
    always_comb begin
        if (d_zero && (item.base_sel != REG_EBP)) begin
            mod = MOD_IND;
        end else if (d_fits8) begin
            mod = MOD_DISP8;
        end else begin
            mod = MOD_DISP32;
        end
    end

    always_comb begin
        case (mod)
            MOD_DISP8:  dsize = 3'd1;
            MOD_DISP32: dsize = 3'd4;
            default:    dsize = 3'd0;
        endcase
    end

    always_comb begin
        head   = {16'h0000, item.opcode_byte};
        hcount = 2'd1;
        tail   = item.disp_value;
        tcount = 3'd0;
        unique case (item.func) inside
            FUNC_RR: begin
                head   = {8'h00, modrm(MOD_REG, item.reg_sel, item.rm_sel),
                          item.opcode_byte};
                hcount = 2'd2;
            end
            FUNC_RI: begin
                head   = {16'h0000, item.opcode_byte + {5'b0, item.reg_sel}};
                tail   = item.imm_value;
                tcount = i_fits8 ? 3'd1 : (i_fits16 ? 3'd2 : 3'd4);
            end
            FUNC_RM, FUNC_MR: begin
                case (item.mem_form)
                    MEM_DISP32: begin
                        head   = {8'h00, modrm(MOD_IND, item.reg_sel, REG_EBP),
                                  item.opcode_byte};
                        hcount = 2'd2;
                        tcount = 3'd4;
                    end
                    MEM_SIB_DISP: begin
                        head   = {sib, modrm(mod, item.reg_sel, REG_ESP),
                                  item.opcode_byte};
                        hcount = 2'd3;
                        tcount = dsize;
                    end
                    MEM_BASE_DISP: begin
                        if (item.base_sel == REG_ESP) begin
                            head   = {SIB_ESP, modrm(mod, item.reg_sel, REG_ESP),
                                      item.opcode_byte};
                            hcount = 2'd3;
                        end else begin
                            head   = {8'h00, modrm(mod, item.reg_sel, item.base_sel),
                                      item.opcode_byte};
                            hcount = 2'd2;
                        end
                        tcount = dsize;
                    end
                    MEM_IDX_DISP: begin
                        head   = {item.scale_shift, item.index_sel, REG_EBP,
                                  modrm(MOD_IND, item.reg_sel, REG_ESP),
                                  item.opcode_byte};
                        hcount = 2'd3;
                        tcount = 3'd4;
                    end
                    default: begin
                        // plain [base], also the unused form codes
                        if (item.base_sel == REG_ESP) begin
                            head   = {SIB_ESP, modrm(MOD_IND, item.reg_sel, REG_ESP),
                                      item.opcode_byte};
                            hcount = 2'd3;
                        end else if (item.base_sel == REG_EBP) begin
                            // [ebp] needs a zero disp8
                            head   = {8'h00, modrm(MOD_DISP8, item.reg_sel, REG_EBP),
                                      item.opcode_byte};
                            hcount = 2'd3;
                        end else begin
                            head   = {8'h00,
                                      modrm(MOD_IND, item.reg_sel, item.base_sel),
                                      item.opcode_byte};
                            hcount = 2'd2;
                        end
                    end
                endcase
            end
            default: begin
                head   = {16'h0000, item.opcode_byte};
                hcount = 2'd1;
            end
        endcase
    end

    assign enc.bytes = {32'h0, head} | ({24'h0, tail} << {hcount, 3'b000});
    assign enc.len   = {1'b0, hcount} + tcount;

endmodule

`default_nettype wire

FILE: rtl/xmse_serializer.sv
// ----------------------------------------------------------------------------
// xmse_serializer
// Byte buffer that hands out an encoded instruction one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

module xmse_serializer
    import xmse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      src_valid,
    output logic      src_ready,
    input  enc_t      src_enc,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [8*MAX_BYTES-1:0] bytes_reg, bytes_next;
    logic [2:0]             left_reg,  left_next;   // bytes still to send
    logic [2:0]             pos_reg,   pos_next;
    logic                   take;

    assign m_valid   = (left_reg != 3'd0);
    assign take      = m_valid && m_ready;
    // refill when empty or when the last byte leaves this cycle
    assign src_ready = !m_valid || (m_ready && (left_reg == 3'd1));

    always_comb begin
        bytes_next = bytes_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        if (src_valid && src_ready) begin
            bytes_next = src_enc.bytes;
            left_next  = src_enc.len;
            pos_next   = 3'd0;
        end else if (take) begin
            bytes_next = bytes_reg >> 8;
            left_next  = left_reg - 3'd1;
            pos_next   = pos_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 3'd0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        pos_reg   <= pos_next;
    end

    assign m_item.code_byte = bytes_reg[7:0];
    assign m_item.byte_pos  = pos_reg;
    assign m_item.last_byte = (left_reg == 3'd1);

endmodule

`default_nettype wire

FILE: rtl/x86_modrm_sib_encoder_unit.sv
// ----------------------------------------------------------------------------
// x86_modrm_sib_encoder_unit
// 32-bit x86 two-operand encoder: opcode, ModRM, SIB, displacement, immediate.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_valid/s_ready    in_item_t  one pre-tokenized instruction
//  m_       out  m_valid/m_ready    out_item_t one code byte, position, last
//
//  An instruction yields 2 to 7 bytes, one per cycle on m_ while m_ready is high;
//  the one-byte result port sets the rate at one instruction per len bytes.
//  The first byte reaches m_ through the input register, then the byte buffer.
//  The next instruction is taken into the input register while the previous
//  one drains, so bytes of consecutive instructions leave without gaps.
//  Reset (aresetn low, synchronous) empties the input register and the byte
//  buffer; m_ stall simply holds the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_modrm_sib_encoder_unit
    import xmse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    in_item_t in_item_reg;
    logic     in_valid_reg, in_valid_next;
    logic     ser_ready;
    enc_t     enc;

    // input register: refills whenever its item moves to the byte buffer
    assign s_ready       = !in_valid_reg || ser_ready;
    assign in_valid_next = (s_valid && s_ready) ||
                           (in_valid_reg && !ser_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // instruction -> byte string
    xmse_encode u_encode (
        .item (in_item_reg),
        .enc  (enc)
    );

    // byte string -> result items
    xmse_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .src_valid (in_valid_reg),
        .src_ready (ser_ready),
        .src_enc   (enc),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

FILE: rtl/xmse_checker.sv
// ----------------------------------------------------------------------------
// xmse_checker
// Port-level checks on the encoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module xmse_checker
    import xmse_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // bytes of one instruction follow without gaps, positions counting up
    a_next_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last_byte |=>
            m_valid && (m_item.byte_pos == 3'($past(m_item.byte_pos) + 3'd1)))
        else $error("byte position did not advance");

    a_first_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.last_byte |=>
            !m_valid || (m_item.byte_pos == 3'd0))
        else $error("new instruction does not start at position 0");

    a_max_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.byte_pos == 3'(MAX_BYTES - 1)) |-> m_item.last_byte)
        else $error("instruction longer than seven bytes");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind x86_modrm_sib_encoder_unit xmse_checker u_xmse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

FILE: test/tb_x86_modrm_sib_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_x86_modrm_sib_encoder_unit
// Self-checking bench for the 32-bit ModRM/SIB instruction encoder. A short
// table of hand-picked instructions comes first, then random instructions,
// under four flow-control phases. Every code byte leaving the block is checked
// against an in-bench encoder, or a hand-typed encoding on the table rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_x86_modrm_sib_encoder_unit;
    import xmse_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int RAND_PER_PHASE = 125;
    localparam int TAIL_CYCLES    = 10;
    localparam int TIMEOUT_CYCLES = 400000;

    // memory form codes the block folds back onto [base]
    localparam logic [2:0] MEM_RSVD_5 = 3'd5;
    localparam logic [2:0] MEM_RSVD_7 = 3'd7;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    x86_modrm_sib_encoder_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // encodings queued by the sender, one per item; len 0 means "ask the encoder"
    enc_t      typed_enc_q[$];
    // code bytes still owed by the block, oldest first
    out_item_t code_byte_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int instr_cnt      = 0;
    int typed_cnt      = 0;
    int byte_cnt       = 0;
    int err_cnt        = 0;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Encoder: builds the byte string of one instruction
    // ------------------------------------------------------------------------
    function automatic void put_byte(inout enc_t e, input logic [7:0] b);
        e.bytes[8*e.len +: 8] = b;
        e.len = e.len + 3'd1;
    endfunction

    function automatic void put_le(inout enc_t e, input logic [31:0] v, input int cnt);
        for (int k = 0; k < cnt; k++) begin
            put_byte(e, v[8*k +: 8]);
        end
    endfunction

    function automatic enc_t encode_instr(input in_item_t it);
        enc_t       e;
        logic [1:0] mod_f;
        e = '0;
        case (it.func)
            FUNC_RR: begin
                put_byte(e, it.opcode_byte);
                put_byte(e, {MOD_REG, it.reg_sel, it.rm_sel});
            end
            FUNC_RI: begin
                // register folded into the opcode, wraps at 8 bits
                put_byte(e, it.opcode_byte + {5'd0, it.reg_sel});
                if (it.imm_value >= -128 && it.imm_value <= 127)
                    put_le(e, it.imm_value, 1);
                else if (it.imm_value >= -32768 && it.imm_value <= 32767)
                    put_le(e, it.imm_value, 2);
                else
                    put_le(e, it.imm_value, 4);
            end
            default: begin
                put_byte(e, it.opcode_byte);
                case (it.mem_form)
                    MEM_DISP32: begin
                        put_byte(e, {MOD_IND, it.reg_sel, REG_EBP});
                        put_le(e, it.disp_value, 4);
                    end
                    MEM_BASE_DISP, MEM_SIB_DISP: begin
                        // EBP base cannot go without a displacement
                        if (it.disp_value == 0 && it.base_sel != REG_EBP)
                            mod_f = MOD_IND;
                        else if (it.disp_value >= -128 && it.disp_value <= 127)
                            mod_f = MOD_DISP8;
                        else
                            mod_f = MOD_DISP32;
                        if (it.mem_form == MEM_SIB_DISP) begin
                            put_byte(e, {mod_f, it.reg_sel, REG_ESP});
                            put_byte(e, {it.scale_shift, it.index_sel, it.base_sel});
                        end else if (it.base_sel == REG_ESP) begin
                            put_byte(e, {mod_f, it.reg_sel, REG_ESP});
                            put_byte(e, SIB_ESP);
                        end else begin
                            put_byte(e, {mod_f, it.reg_sel, it.base_sel});
                        end
                        if (mod_f == MOD_DISP8)
                            put_le(e, it.disp_value, 1);
                        else if (mod_f == MOD_DISP32)
                            put_le(e, it.disp_value, 4);
                    end
                    MEM_IDX_DISP: begin
                        put_byte(e, {MOD_IND, it.reg_sel, REG_ESP});
                        put_byte(e, {it.scale_shift, it.index_sel, REG_EBP});
                        put_le(e, it.disp_value, 4);
                    end
                    default: begin
                        // plain [base], also the spare form codes
                        if (it.base_sel == REG_ESP) begin
                            put_byte(e, {MOD_IND, it.reg_sel, REG_ESP});
                            put_byte(e, SIB_ESP);
                        end else if (it.base_sel == REG_EBP) begin
                            put_byte(e, {MOD_DISP8, it.reg_sel, REG_EBP});
                            put_byte(e, 8'h00);
                        end else begin
                            put_byte(e, {MOD_IND, it.reg_sel, it.base_sel});
                        end
                    end
                endcase
            end
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_item_t mk_instr(input logic [1:0] func, input logic [7:0] opc,
                                          input logic [2:0] reg_f, input logic [2:0] rm_f,
                                          input logic [2:0] form, input logic [2:0] base,
                                          input logic [2:0] index, input logic [1:0] scale,
                                          input logic [31:0] disp, input logic [31:0] imm);
        in_item_t it;
        it.func        = func;
        it.opcode_byte = opc;
        it.reg_sel     = reg_f;
        it.rm_sel      = rm_f;
        it.mem_form    = form;
        it.base_sel    = base;
        it.index_sel   = index;
        it.scale_shift = scale;
        it.disp_value  = disp;
        it.imm_value   = imm;
        return it;
    endfunction

    function automatic enc_t typed(input logic [55:0] b, input logic [2:0] n);
        enc_t e;
        e.bytes = b;
        e.len   = n;
        return e;
    endfunction

    // values spread over the 1/2/4 byte size classes and their borders
    function automatic logic [31:0] rand_word();
        logic [31:0] bounds [8];
        bounds = '{-129, 128, -32769, 32768, 32'h7FFF_FFFF, 32'h8000_0000, -1, 1};
        case ($urandom_range(6))
            0:       return '0;
            1:       return $urandom_range(255) - 128;
            2:       return $urandom_range(65535) - 32768;
            3:       return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
            4:       return bounds[$urandom_range(7)];
            default: return $urandom();
        endcase
    endfunction

    function automatic in_item_t rand_instr();
        in_item_t it;
        it.func        = 2'($urandom_range(3));
        it.opcode_byte = 8'($urandom_range(255));
        it.reg_sel     = 3'($urandom_range(7));
        it.rm_sel      = 3'($urandom_range(7));
        it.mem_form    = ($urandom_range(9) == 0) ? 3'($urandom_range(MEM_RSVD_7, MEM_RSVD_5))
                                                  : 3'($urandom_range(MEM_IDX_DISP, MEM_BASE));
        // lean on the ESP/EBP special cases
        it.base_sel    = ($urandom_range(2) == 0) ? ($urandom_range(1) ? REG_ESP : REG_EBP)
                                                  : 3'($urandom_range(7));
        it.index_sel   = 3'($urandom_range(7));
        it.scale_shift = 2'($urandom_range(3));
        it.disp_value  = rand_word();
        it.imm_value   = rand_word();
        return it;
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_instr(input in_item_t it, input enc_t known);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        typed_enc_q.push_back(known);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender off until the block has handed back every owed byte
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (typed_enc_q.size() != 0 || code_byte_q.size() != 0);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: expand accepted items into owed bytes, check bytes as they leave
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        enc_t      enc;
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                enc = typed_enc_q.pop_front();
                if (enc.len == 0)
                    enc = encode_instr(s_item);
                else
                    typed_cnt++;
                instr_cnt++;
                for (int k = 0; k < enc.len; k++) begin
                    want.code_byte = enc.bytes[8*k +: 8];
                    want.byte_pos  = 3'(k);
                    want.last_byte = (k == enc.len - 1);
                    code_byte_q.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                byte_cnt++;
                if (code_byte_q.size() == 0) begin
                    $error("unexpected code byte %02h at position %0d",
                           m_item.code_byte, m_item.byte_pos);
                    err_cnt++;
                end else begin
                    want = code_byte_q.pop_front();
                    if (m_item.code_byte !== want.code_byte) begin
                        $error("code_byte: expected %02h, got %02h",
                               want.code_byte, m_item.code_byte);
                        err_cnt++;
                    end
                    if (m_item.byte_pos !== want.byte_pos) begin
                        $error("byte_pos: expected %0d, got %0d",
                               want.byte_pos, m_item.byte_pos);
                        err_cnt++;
                    end
                    if (m_item.last_byte !== want.last_byte) begin
                        $error("last_byte: expected %0b, got %0b",
                               want.last_byte, m_item.last_byte);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        in_item_t dir_item_q[$];
        enc_t     dir_enc_q[$];

        // Directed table. Rows with a typed encoding are the extremes whose
        // bytes are plain to see; the rest go through the encoder.
        // register-register, all-ones and all-zeros
        dir_item_q.push_back(mk_instr(FUNC_RR, 8'hFF, 7, 7, MEM_BASE, 0, 0, 0, 0, 0));
        dir_enc_q.push_back(typed(56'hFFFF, 2));
        dir_item_q.push_back(mk_instr(FUNC_RR, 8'h00, 0, 0, MEM_BASE, 0, 0, 0, 0, 0));
        dir_enc_q.push_back(typed(56'hC000, 2));
        // immediate size borders
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 0, 0, MEM_BASE, 0, 0, 0, 0, 127));
        dir_enc_q.push_back(typed(56'h7FB8, 2));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 0, 0, MEM_BASE, 0, 0, 0, 0, -128));
        dir_enc_q.push_back(typed(56'h80B8, 2));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 0, 0, MEM_BASE, 0, 0, 0, 0, -32768));
        dir_enc_q.push_back(typed(56'h8000B8, 3));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 0, 0, MEM_BASE, 0, 0, 0, 0, 32767));
        dir_enc_q.push_back(typed(56'h7FFFB8, 3));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 0, 0, MEM_BASE, 0, 0, 0, 0,
                                      32'h7FFF_FFFF));
        dir_enc_q.push_back(typed(56'h7FFFFFFFB8, 5));
        // opcode + register wraps past 0xFF
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hFF, 7, 0, MEM_BASE, 0, 0, 0, 0,
                                      32'h8000_0000));
        dir_enc_q.push_back(typed(56'h8000000006, 5));
        // absolute disp32, most negative
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h8B, 7, 0, MEM_DISP32, 0, 0, 0,
                                      32'h8000_0000, 0));
        dir_enc_q.push_back(typed(56'h800000003D8B, 6));
        // longest instruction: SIB with disp32
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h89, 7, 0, MEM_SIB_DISP, 7, 7, 3,
                                      32'h7FFF_FFFF, 0));
        dir_enc_q.push_back(typed(56'h7FFFFFFFFFBC89, 7));
        // just past the immediate borders at 127, 32767 and -128
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 3, 0, MEM_BASE, 0, 0, 0, 0, 128));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 3, 0, MEM_BASE, 0, 0, 0, 0, 32768));
        dir_item_q.push_back(mk_instr(FUNC_RI, 8'hB8, 3, 0, MEM_BASE, 0, 0, 0, 0, -129));
        // [base]: ordinary, ESP base, EBP base
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h8B, 1, 0, MEM_BASE, 0, 0, 0, 0, 0));
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h8B, 1, 0, MEM_BASE, REG_ESP, 0, 0, 0, 0));
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h8B, 1, 0, MEM_BASE, REG_EBP, 0, 0, 0, 0));
        // [base+disp]: EBP with zero, ESP with disp8 low end, disp32 just past disp8
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h89, 2, 0, MEM_BASE_DISP, REG_EBP,
                                      0, 0, 0, 0));
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h89, 2, 0, MEM_BASE_DISP, REG_ESP,
                                      0, 0, -128, 0));
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h89, 2, 0, MEM_BASE_DISP, 2, 0, 0, 128, 0));
        // SIB: EBP base with zero disp, no-index code with ESP base
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h03, 5, 0, MEM_SIB_DISP, REG_EBP,
                                      REG_ESP, 0, 0, 0));
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h03, 5, 0, MEM_SIB_DISP, REG_ESP,
                                      REG_ESP, 1, -129, 0));
        // index only: disp32 even when zero
        dir_item_q.push_back(mk_instr(FUNC_RM, 8'h03, 6, 0, MEM_IDX_DISP, 0, 7, 2, 0, 0));
        // spare form codes fall back to [base]; the displacement is ignored
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h01, 0, 0, MEM_RSVD_5, REG_EBP, 3, 1,
                                      32'h1234_5678, 0));
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h01, 0, 0, MEM_RSVD_5 + 3'd1, REG_ESP, 3, 1,
                                      -1, 0));
        dir_item_q.push_back(mk_instr(FUNC_MR, 8'h01, 0, 0, MEM_RSVD_7, 1, 3, 1, 77, -5));
        while (dir_enc_q.size() < dir_item_q.size())
            dir_enc_q.push_back('0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phases: free flow, sparse sender, slow receiver, both sides choppy
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 0) begin
                foreach (dir_item_q[k])
                    send_instr(dir_item_q[k], dir_enc_q[k]);
                wait_drained();
            end
            repeat (RAND_PER_PHASE)
                send_instr(rand_instr(), '0);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Encoded %0d instructions (%0d with typed bytes), %0d code bytes checked,",
                 instr_cnt, typed_cnt, byte_cnt);
        $display("across free-flow, idle-sender, stalled-receiver and mixed phases");
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
